/* design/cpu_bus_decode_with_pads_top_defines.svh */
// assertion macros shared by the bus decoder checker
// expects clk_i and rst_ni in the scope of each use
`ifndef CPU_BUS_DECODE_WITH_PADS_TOP_DEFINES_SVH
`define CPU_BUS_DECODE_WITH_PADS_TOP_DEFINES_SVH

// sampled property, quiet while reset is asserted
`define CBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication, quiet while reset is asserted
`define CBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* design/cbd_pkg.sv */
// shared types and constants for the cpu bus decoder
// no dependencies
`timescale 1ns / 1ps

package cbd_pkg;

  // default work ram size in bytes
  localparam int unsigned RAM_BYTES_DEF = 2048;

  // width of the ram mirror window (0x0000..0x1FFF)
  localparam int unsigned MIRROR_W = 13;

  // address map
  localparam logic [15:0] ADDR_RAM_END = 16'h1FFF;
  localparam logic [15:0] ADDR_PPU_END = 16'h3FFF;
  localparam logic [15:0] ADDR_DMA     = 16'h4014;
  localparam logic [15:0] ADDR_PAD1    = 16'h4016;
  localparam logic [15:0] ADDR_PAD2    = 16'h4017;
  localparam logic [15:0] ADDR_IO_END  = 16'h401F;
  localparam logic [15:0] ADDR_CART    = 16'h8000;

  // bus latch bits kept on a pad read
  localparam logic [7:0] LATCH_KEEP_MASK = 8'hE0;

  typedef enum logic [2:0] {
    TGT_RAM  = 3'd0,
    TGT_PPU  = 3'd1,
    TGT_PAD1 = 3'd2,
    TGT_PAD2 = 3'd3,
    TGT_IO   = 3'd4,
    TGT_DMA  = 3'd5,
    TGT_CART = 3'd6,
    TGT_NONE = 3'd7
  } tgt_e;

  // one bus access
  typedef struct packed {
    logic       operation;
    logic [15:0] address;
    logic [7:0] write_data;
    logic [7:0] pad_one_buttons;
    logic [7:0] pad_two_buttons;
    logic [7:0] slave_data;
    logic       cart_hit;
  } cbd_in_t;

  // one decoded result
  typedef struct packed {
    logic [7:0] read_data;
    tgt_e       target;
    logic [2:0] ppu_reg_index;
    logic       ppu_write;
    logic       cart_write;
    logic       dma_start;
    logic [7:0] dma_page;
  } cbd_out_t;

  // ram access request from the core
  typedef struct packed {
    logic                rd_en;
    logic [MIRROR_W-1:0] rd_addr;
    logic                wr_en;
    logic [MIRROR_W-1:0] wr_addr;
    logic [7:0]          wr_data;
  } cbd_ram_req_t;

  // ram response to the core
  typedef struct packed {
    logic       ready;
    logic [7:0] rd_data;
  } cbd_ram_rsp_t;

endpackage

/* design/cbd_ram.sv */
// work ram: synchronous memory with post-reset clearing pass,
// mirror folding and write-to-read forwarding; uses cbd_pkg
`timescale 1ns / 1ps

module cbd_ram #(
  parameter int unsigned RAM_BYTES = cbd_pkg::RAM_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cbd_pkg::cbd_ram_req_t req_i,
  output cbd_pkg::cbd_ram_rsp_t rsp_o
);
  import cbd_pkg::*;

  localparam int unsigned IDX_W     = $clog2(RAM_BYTES);
  localparam int unsigned SPAN      = 1 << MIRROR_W;
  localparam int          MOD_STEPS = $clog2(SPAN / RAM_BYTES + 1);

  logic [7:0]       mem [RAM_BYTES];
  logic [7:0]       rd_q;
  logic             fwd_q;
  logic [7:0]       fwd_data_q;
  logic             clr_active_q;
  logic [IDX_W-1:0] clr_idx_q;

  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;
  logic             mem_we;
  logic [IDX_W-1:0] mem_widx;
  logic [7:0]       mem_wdata;

  // mirror address modulo ram size, restoring subtract one quotient bit a step
  function automatic logic [IDX_W-1:0] fold_idx(input logic [MIRROR_W-1:0] addr);
    logic [MIRROR_W:0] rem;
    logic [MIRROR_W:0] sub;
    rem = {1'b0, addr};
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      sub = (MIRROR_W + 1)'(RAM_BYTES << k);
      if (rem >= sub) begin
        rem = rem - sub;
      end
    end
    return rem[IDX_W-1:0];
  endfunction

  assign rd_idx = fold_idx(req_i.rd_addr);
  assign wr_idx = fold_idx(req_i.wr_addr);

  // clearing pass owns the write port until it is done
  always_comb begin
    if (clr_active_q) begin
      mem_we    = 1'b1;
      mem_widx  = clr_idx_q;
      mem_wdata = 8'h00;
    end else begin
      mem_we    = req_i.wr_en;
      mem_widx  = wr_idx;
      mem_wdata = req_i.wr_data;
    end
  end

  // memory array
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_widx] <= mem_wdata;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[rd_idx];
    end
  end

  // clearing sweep and forwarding of a same-edge write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_idx_q    <= '0;
      fwd_q        <= 1'b0;
      fwd_data_q   <= 8'h00;
    end else begin
      if (clr_active_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == IDX_W'(RAM_BYTES - 1)) begin
          clr_active_q <= 1'b0;
        end
      end
      if (req_i.rd_en) begin
        fwd_q      <= req_i.wr_en && (wr_idx == rd_idx);
        fwd_data_q <= req_i.wr_data;
      end
    end
  end

  assign rsp_o.ready   = !clr_active_q;
  assign rsp_o.rd_data = fwd_q ? fwd_data_q : rd_q;

endmodule

/* design/cbd_core.sv */
// decode core: holding stage, address decode, bus latch, pad ports
// and output register; uses cbd_pkg and drives cbd_ram
`timescale 1ns / 1ps

module cbd_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cbd_pkg::cbd_in_t      in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output cbd_pkg::cbd_out_t     out_data_o,
  output cbd_pkg::cbd_ram_req_t ram_req_o,
  input  cbd_pkg::cbd_ram_rsp_t ram_rsp_i
);
  import cbd_pkg::*;

  logic     s1_valid_q;
  cbd_in_t  s1_item_q;
  logic     out_valid_q;
  cbd_out_t out_q;
  logic [7:0] latch_q, latch_d;
  logic       strobe_q, strobe_d;
  logic [7:0] shift1_q, shift1_d;
  logic [7:0] shift2_q, shift2_d;

  logic     s1_adv;
  logic     in_acc;
  logic     ram_we;
  cbd_out_t res;
  logic [15:0] a;
  logic        pad_bit;

  // handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = ram_rsp_i.ready && (!s1_valid_q || s1_adv);
  assign in_acc     = in_valid_i && in_ready_o;
  assign a          = s1_item_q.address;

  // decode of the held beat
  always_comb begin
    latch_d  = latch_q;
    strobe_d = strobe_q;
    shift1_d = shift1_q;
    shift2_d = shift2_q;
    ram_we   = 1'b0;
    pad_bit  = 1'b0;
    res      = '0;
    res.target = TGT_NONE;
    if (!s1_item_q.operation) begin
      if (a <= ADDR_RAM_END) begin
        latch_d    = ram_rsp_i.rd_data;
        res.target = TGT_RAM;
      end else if (a <= ADDR_PPU_END) begin
        latch_d           = s1_item_q.slave_data;
        res.target        = TGT_PPU;
        res.ppu_reg_index = a[2:0];
      end else if (a == ADDR_PAD1) begin
        if (strobe_q) begin
          pad_bit = s1_item_q.pad_one_buttons[0];
        end else begin
          pad_bit  = shift1_q[0];
          shift1_d = {1'b1, shift1_q[7:1]};
        end
        latch_d    = (latch_q & LATCH_KEEP_MASK) | {7'd0, pad_bit};
        res.target = TGT_PAD1;
      end else if (a == ADDR_PAD2) begin
        if (strobe_q) begin
          pad_bit = s1_item_q.pad_two_buttons[0];
        end else begin
          pad_bit  = shift2_q[0];
          shift2_d = {1'b1, shift2_q[7:1]};
        end
        latch_d    = (latch_q & LATCH_KEEP_MASK) | {7'd0, pad_bit};
        res.target = TGT_PAD2;
      end else if (a <= ADDR_IO_END) begin
        res.target = TGT_IO;
      end else if (s1_item_q.cart_hit) begin
        latch_d    = s1_item_q.slave_data;
        res.target = TGT_CART;
      end
    end else begin
      latch_d = s1_item_q.write_data;
      if (a <= ADDR_RAM_END) begin
        ram_we     = 1'b1;
        res.target = TGT_RAM;
      end else if (a <= ADDR_PPU_END) begin
        res.target        = TGT_PPU;
        res.ppu_reg_index = a[2:0];
        res.ppu_write     = 1'b1;
      end else if (a == ADDR_DMA) begin
        res.target    = TGT_DMA;
        res.dma_start = 1'b1;
        res.dma_page  = s1_item_q.write_data;
      end else if (a == ADDR_PAD1) begin
        if (strobe_q || s1_item_q.write_data[0]) begin
          shift1_d = s1_item_q.pad_one_buttons;
          shift2_d = s1_item_q.pad_two_buttons;
        end
        strobe_d   = s1_item_q.write_data[0];
        res.target = TGT_PAD1;
      end else if (a <= ADDR_IO_END) begin
        res.target = TGT_IO;
      end else if (a >= ADDR_CART) begin
        res.target     = TGT_CART;
        res.cart_write = 1'b1;
      end
    end
    res.read_data = latch_d;
  end

  // ram read at accept, write back when the held beat retires
  assign ram_req_o.rd_en   = in_acc;
  assign ram_req_o.rd_addr = in_data_i.address[MIRROR_W-1:0];
  assign ram_req_o.wr_en   = s1_adv && ram_we;
  assign ram_req_o.wr_addr = a[MIRROR_W-1:0];
  assign ram_req_o.wr_data = s1_item_q.write_data;

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      latch_q     <= 8'h00;
      strobe_q    <= 1'b0;
      shift1_q    <= 8'h00;
      shift2_q    <= 8'h00;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        latch_q     <= latch_d;
        strobe_q    <= strobe_d;
        shift1_q    <= shift1_d;
        shift2_q    <= shift2_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_data_i;
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* design/cpu_bus_decode_with_pads_top.sv */
// top level of the cpu bus decoder with work ram and game-pad ports
// depends on cbd_pkg, cbd_ram and cbd_core
`timescale 1ns / 1ps

// usage
// - input channel in_valid_i / in_ready_o / in_data_i carries one cpu bus
//   access per beat: operation, address, write data, live pad buttons and
//   the slave read data with its cartridge hit flag
// - output channel out_valid_o / out_ready_i / out_data_o returns one
//   decoded result per access, in order
// - an accepted access waits in the holding stage, then its result goes
//   to the output register; one access per cycle is taken while the
//   receiver keeps up; the ram is read at accept and written back as the
//   held beat retires, with a same-address write forwarded to the next read
// - a two-beat buffer (holding stage plus output register) lets one
//   access be accepted while a result waits; a stalled receiver holds the
//   result and, once both are full, in_ready_o drops
// - reset clears the bus latch, pad strobe and shift registers, then a
//   clearing pass writes zero to all work ram entries, one per cycle;
//   in_ready_o stays low until it ends
module cpu_bus_decode_with_pads_top #(
  parameter int unsigned RAM_BYTES = cbd_pkg::RAM_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cbd_pkg::cbd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cbd_pkg::cbd_out_t out_data_o
);
  import cbd_pkg::*;

  cbd_ram_req_t ram_req;
  cbd_ram_rsp_t ram_rsp;

  // decode and state
  cbd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .ram_req_o  (ram_req),
    .ram_rsp_i  (ram_rsp)
  );

  // work ram
  cbd_ram #(
    .RAM_BYTES(RAM_BYTES)
  ) u_ram (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (ram_req),
    .rsp_o (ram_rsp)
  );

endmodule

/* design/cbd_checker.sv */
// port-level checker for the cpu bus decoder, bound to the top level
// depends on cbd_pkg and cpu_bus_decode_with_pads_top_defines.svh
`timescale 1ns / 1ps
`include "cpu_bus_decode_with_pads_top_defines.svh"

module cbd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input cbd_pkg::cbd_out_t out_data_o
);
  import cbd_pkg::*;

  logic [2:0] pending_q;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid_i && in_ready_o;
  assign out_beat = out_valid_o && out_ready_i;

  // accesses accepted but not yet returned
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 3'd0;
    end else begin
      pending_q <= pending_q + {2'd0, in_beat} - {2'd0, out_beat};
    end
  end

  // a stalled result holds
  `CBD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result changed while stalled")
  // no result without an access behind it
  `CBD_ASSERT_IMP(a_no_phantom, out_valid_o, pending_q != 3'd0, "result with no access pending")
  // at most two accesses in flight
  `CBD_ASSERT_IMP(a_depth, 1'b1, pending_q <= 3'd2, "more than two accesses in flight")
  // a dma request reports its page as the latched bus byte
  `CBD_ASSERT_IMP(a_dma_page, out_valid_o && out_data_o.dma_start, out_data_o.dma_page == out_data_o.read_data && out_data_o.target == TGT_DMA, "dma request page mismatch")

endmodule

bind cpu_bus_decode_with_pads_top cbd_checker u_cbd_checker (.*);
